FILE: rtl/core/ilbp_code_histogram_top_macros.svh
// assertion helpers for the code histogram checker
`ifndef ILBP_CODE_HISTOGRAM_TOP_MACROS_SVH
`define ILBP_CODE_HISTOGRAM_TOP_MACROS_SVH

// condition and consequence in the same cycle
`define ILBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilbp: same-cycle check failed");

// consequence in the cycle after the condition
`define ILBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilbp: next-cycle check failed");

`endif

FILE: rtl/core/ilbp_pkg.sv
package ilbp_pkg;

    // window and code geometry
    localparam int WIN_SIZE  = 9;
    localparam int CODE_BITS = 9;
    localparam int NUM_BINS  = 512;
    localparam int MEAN_BITS = 8;

    localparam logic [CODE_BITS-1:0] CODE_MAX = 9'd511;

    // output buffer
    localparam int OUT_DEPTH    = 8;
    localparam int OUT_PTR_BITS = 3;
    localparam int CREDIT_BITS  = 4;

    // one item travelling toward the histogram
    typedef struct packed {
        logic                 valid;
        logic [CODE_BITS-1:0] code;
        logic [MEAN_BITS-1:0] mean;
    } tag_t;

endpackage

FILE: rtl/core/ilbp_lane.sv
// one threshold lane: compares its pixel against the window mean
module ilbp_lane #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                  clk,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic [PIXEL_BITS-1:0] mean,
    output logic                  hit
);

    logic hit_reg;
    logic hit_next;

    // pixel at or above the mean gives a one
    assign hit_next = (pixel >= mean);

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign hit = hit_reg;

endmodule

FILE: rtl/core/ilbp_merge.sv
// merges the lane bits: smallest of the nine left rotations of the word
module ilbp_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid,
    input  logic [ilbp_pkg::MEAN_BITS-1:0]      mean,
    input  logic [ilbp_pkg::CODE_BITS-1:0]      word,
    output ilbp_pkg::tag_t                      tag
);

    localparam int CB = ilbp_pkg::CODE_BITS;

    logic [2*CB-1:0]     dbl;
    logic [CB-1:0]       rot [ilbp_pkg::WIN_SIZE];
    logic [CB-1:0]       best;
    ilbp_pkg::tag_t      tag_reg;
    ilbp_pkg::tag_t      tag_next;

    // all rotations come out of the doubled word
    assign dbl = {word, word};

    for (genvar k = 0; k < ilbp_pkg::WIN_SIZE; k++)
    begin : g_rot
        assign rot[k] = dbl[2*CB-1-k -: CB];
    end

    // running minimum over the rotations
    always_comb
    begin
        best = rot[0];
        for (int k = 1; k < ilbp_pkg::WIN_SIZE; k++)
        begin
            if (rot[k] < best)
            begin
                best = rot[k];
            end
        end
    end

    always_comb
    begin
        tag_next.valid = valid;
        tag_next.code  = best;
        tag_next.mean  = mean;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_next;
        end
    end

    assign tag = tag_reg;

endmodule

FILE: rtl/core/ilbp_hist.sv
// histogram bins: clearing pass, read-modify-write with forwarding
module ilbp_hist #(
    parameter int COUNT_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ilbp_pkg::tag_t        tag,
    output logic                  clear_busy,
    output ilbp_pkg::tag_t        done,
    output logic [COUNT_BITS-1:0] count
);

    localparam int CB = ilbp_pkg::CODE_BITS;

    logic [COUNT_BITS-1:0] mem [ilbp_pkg::NUM_BINS];

    ilbp_pkg::tag_t        tag6_reg;
    logic                  fwd_reg;
    logic                  fwd_next;
    logic [COUNT_BITS-1:0] fwd_val_reg;
    logic [COUNT_BITS-1:0] rd_raw_reg;
    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] new_count;
    logic                  clear_busy_reg;
    logic [CB-1:0]         clear_idx_reg;
    logic                  wr_en;
    logic [CB-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    // older count comes from the bin or from the item just ahead
    assign base      = fwd_reg ? fwd_val_reg : rd_raw_reg;
    assign new_count = (base == '1) ? base : base + COUNT_BITS'(1);
    assign fwd_next  = tag6_reg.valid && tag.valid && (tag.code == tag6_reg.code);

    // write port shared by clearing pass and updates
    assign wr_en   = clear_busy_reg || tag6_reg.valid;
    assign wr_addr = clear_busy_reg ? clear_idx_reg : tag6_reg.code;
    assign wr_data = clear_busy_reg ? '0 : new_count;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_raw_reg  <= mem[tag.code];
        fwd_val_reg <= new_count;
    end

    // control: clearing pass and update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_idx_reg  <= '0;
            tag6_reg       <= '0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            tag6_reg <= tag;
            fwd_reg  <= fwd_next;
            if (clear_busy_reg)
            begin
                clear_idx_reg <= clear_idx_reg + CB'(1);
                if (clear_idx_reg == CB'(ilbp_pkg::NUM_BINS - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign clear_busy = clear_busy_reg;
    assign done       = tag6_reg;
    assign count      = new_count;

endmodule

FILE: rtl/core/ilbp_out_fifo.sv
// result buffer between the pipeline and the output channel
module ilbp_out_fifo #(
    parameter int COUNT_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ilbp_pkg::tag_t                    push,
    input  logic [COUNT_BITS-1:0]             push_count,
    input  logic                              pop,
    output logic                              out_valid,
    output logic [ilbp_pkg::CODE_BITS-1:0]    pattern_code,
    output logic [ilbp_pkg::MEAN_BITS-1:0]    window_mean,
    output logic [COUNT_BITS-1:0]             bin_count
);

    localparam int PB = ilbp_pkg::OUT_PTR_BITS;
    localparam int FB = ilbp_pkg::CREDIT_BITS;

    logic [ilbp_pkg::CODE_BITS-1:0] code_mem  [ilbp_pkg::OUT_DEPTH];
    logic [ilbp_pkg::MEAN_BITS-1:0] mean_mem  [ilbp_pkg::OUT_DEPTH];
    logic [COUNT_BITS-1:0]          count_mem [ilbp_pkg::OUT_DEPTH];

    logic [PB-1:0] wr_ptr_reg;
    logic [PB-1:0] rd_ptr_reg;
    logic [FB-1:0] fill_reg;
    logic [FB-1:0] fill_next;

    assign fill_next = fill_reg + FB'(push.valid) - FB'(pop);

    // storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            code_mem[wr_ptr_reg]  <= push.code;
            mean_mem[wr_ptr_reg]  <= push.mean;
            count_mem[wr_ptr_reg] <= push_count;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PB'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PB'(1);
            end
            fill_reg <= fill_next;
        end
    end

    assign out_valid    = (fill_reg != '0);
    assign pattern_code = code_mem[rd_ptr_reg];
    assign window_mean  = mean_mem[rd_ptr_reg];
    assign bin_count    = count_mem[rd_ptr_reg];

endmodule

FILE: rtl/core/ilbp_code_histogram_top.sv
// Improved 3x3 local binary pattern with a running 512-bin code histogram.
// One window is accepted per clock while in_stall is low; each gives one
// result (pattern code, window mean, new bin count) that passes the front
// pipeline, lane, merge and histogram registers and the result buffer
// before it reaches the output. The rate is set by a nine-lane threshold
// stage and a single histogram memory whose read-modify-write is forwarded
// between neighboring items. After reset a clearing pass over all 512 bins
// holds in_stall high. An 8-entry result buffer with credit flow control
// lets the input keep running while results wait; once 8 items are
// outstanding the input stalls. Bins saturate at 2^COUNT_BITS - 1.
module ilbp_code_histogram_top #(
    parameter int PIXEL_BITS = 8,
    parameter int COUNT_BITS = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [PIXEL_BITS-1:0]              pixel_0,
    input  logic [PIXEL_BITS-1:0]              pixel_1,
    input  logic [PIXEL_BITS-1:0]              pixel_2,
    input  logic [PIXEL_BITS-1:0]              pixel_3,
    input  logic [PIXEL_BITS-1:0]              pixel_4,
    input  logic [PIXEL_BITS-1:0]              pixel_5,
    input  logic [PIXEL_BITS-1:0]              pixel_6,
    input  logic [PIXEL_BITS-1:0]              pixel_7,
    input  logic [PIXEL_BITS-1:0]              pixel_8,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ilbp_pkg::CODE_BITS-1:0]     pattern_code,
    output logic [ilbp_pkg::MEAN_BITS-1:0]     window_mean,
    output logic [COUNT_BITS-1:0]              bin_count
);

    localparam int WS        = ilbp_pkg::WIN_SIZE;
    localparam int FB        = ilbp_pkg::CREDIT_BITS;
    localparam int SUM_BITS  = PIXEL_BITS + 4;
    localparam int SHIFT     = SUM_BITS + 4;
    localparam int PROD_BITS = 2 * SUM_BITS + 1;
    localparam logic [SUM_BITS:0] RECIP =
        (SUM_BITS + 1)'(((64'd1 << SHIFT) + 64'd8) / 64'd9);

    logic                  in_accept;
    logic                  out_accept;
    logic                  clear_busy;
    logic [FB-1:0]         credit_reg;
    logic [FB-1:0]         credit_next;

    logic [PIXEL_BITS-1:0] pix_in   [WS];
    logic [PIXEL_BITS-1:0] pix1_reg [WS];
    logic [PIXEL_BITS-1:0] pix2_reg [WS];
    logic [PIXEL_BITS-1:0] pix3_reg [WS];
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  v4_reg;
    logic [SUM_BITS-1:0]   sum_next;
    logic [SUM_BITS-1:0]   sum2_reg;
    logic [PROD_BITS-1:0]  prod3_reg;
    logic [PIXEL_BITS-1:0] mean3;
    logic [ilbp_pkg::MEAN_BITS-1:0] mean4_reg;
    logic [ilbp_pkg::CODE_BITS-1:0] word4;

    ilbp_pkg::tag_t        tag5;
    ilbp_pkg::tag_t        tag6;
    logic [COUNT_BITS-1:0] count6;

    // handshakes and credit for the result buffer
    assign in_accept   = in_valid && !in_stall;
    assign out_accept  = out_valid && !out_stall;
    assign credit_next = credit_reg + FB'(in_accept) - FB'(out_accept);
    assign in_stall    = clear_busy || (credit_reg == FB'(ilbp_pkg::OUT_DEPTH));

    assign pix_in[0] = pixel_0;
    assign pix_in[1] = pixel_1;
    assign pix_in[2] = pixel_2;
    assign pix_in[3] = pixel_3;
    assign pix_in[4] = pixel_4;
    assign pix_in[5] = pixel_5;
    assign pix_in[6] = pixel_6;
    assign pix_in[7] = pixel_7;
    assign pix_in[8] = pixel_8;

    // adder tree over the window
    assign sum_next = ((SUM_BITS'(pix1_reg[0]) + SUM_BITS'(pix1_reg[1]))
                     + (SUM_BITS'(pix1_reg[2]) + SUM_BITS'(pix1_reg[3])))
                    + ((SUM_BITS'(pix1_reg[4]) + SUM_BITS'(pix1_reg[5]))
                     + (SUM_BITS'(pix1_reg[6]) + SUM_BITS'(pix1_reg[7])))
                    + SUM_BITS'(pix1_reg[8]);

    // divide by nine through the reciprocal product
    assign mean3 = prod3_reg[SHIFT +: PIXEL_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
        end
        else
        begin
            credit_reg <= credit_next;
            v1_reg     <= in_accept;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
        end
    end

    // front pipeline payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WS; i++)
        begin
            pix1_reg[i] <= pix_in[i];
            pix2_reg[i] <= pix1_reg[i];
            pix3_reg[i] <= pix2_reg[i];
        end
        sum2_reg  <= sum_next;
        prod3_reg <= PROD_BITS'(sum2_reg) * PROD_BITS'(RECIP);
        mean4_reg <= ilbp_pkg::MEAN_BITS'(mean3);
    end

    // threshold lanes, first pixel lands in the top bit
    for (genvar i = 0; i < WS; i++)
    begin : g_lane
        ilbp_lane #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_lane (
            .clk   (clk),
            .pixel (pix3_reg[i]),
            .mean  (mean3),
            .hit   (word4[WS-1-i])
        );
    end

    ilbp_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (v4_reg),
        .mean  (mean4_reg),
        .word  (word4),
        .tag   (tag5)
    );

    ilbp_hist #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag5),
        .clear_busy (clear_busy),
        .done       (tag6),
        .count      (count6)
    );

    ilbp_out_fifo #(
        .COUNT_BITS (COUNT_BITS)
    ) u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (tag6),
        .push_count   (count6),
        .pop          (out_accept),
        .out_valid    (out_valid),
        .pattern_code (pattern_code),
        .window_mean  (window_mean),
        .bin_count    (bin_count)
    );

endmodule

FILE: rtl/core/ilbp_chk.sv
`include "ilbp_code_histogram_top_macros.svh"

// port-level checks on the code histogram
module ilbp_chk #(
    parameter int COUNT_BITS = 20
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [ilbp_pkg::CODE_BITS-1:0] pattern_code,
    input logic [COUNT_BITS-1:0]          bin_count
);

    logic [7:0] pend_reg;
    logic [7:0] pend_next;

    // items accepted and not yet delivered
    assign pend_next = pend_reg + 8'(in_valid && !in_stall) - 8'(out_valid && !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // a held result stays put
    `ILBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pattern_code) && $stable(bin_count))

    // a fresh result has a counted bin and a rotation-minimal code
    `ILBP_ASSERT_NOW(a_out_fresh, $rose(out_valid), (bin_count != '0) && ((pattern_code == ilbp_pkg::CODE_MAX) || !pattern_code[ilbp_pkg::CODE_BITS-1]))

    // no result without an item behind it
    `ILBP_ASSERT_NOW(a_no_extra, out_valid, pend_reg != 8'd0)

endmodule

bind ilbp_code_histogram_top ilbp_chk #(
    .COUNT_BITS (COUNT_BITS)
) u_ilbp_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pattern_code (pattern_code),
    .bin_count    (bin_count)
);

FILE: bench/ilbp_code_histogram_checker.sv
`timescale 1ns / 1ps

// watches both channels, predicts each result and compares it in order
module ilbp_code_histogram_checker #(
    parameter int PIXEL_BITS = 8,
    parameter int COUNT_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [PIXEL_BITS-1:0]          pixel_0,
    input  logic [PIXEL_BITS-1:0]          pixel_1,
    input  logic [PIXEL_BITS-1:0]          pixel_2,
    input  logic [PIXEL_BITS-1:0]          pixel_3,
    input  logic [PIXEL_BITS-1:0]          pixel_4,
    input  logic [PIXEL_BITS-1:0]          pixel_5,
    input  logic [PIXEL_BITS-1:0]          pixel_6,
    input  logic [PIXEL_BITS-1:0]          pixel_7,
    input  logic [PIXEL_BITS-1:0]          pixel_8,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [ilbp_pkg::CODE_BITS-1:0] pattern_code,
    input  logic [ilbp_pkg::MEAN_BITS-1:0] window_mean,
    input  logic [COUNT_BITS-1:0]          bin_count,
    output int                             fail_count,
    output int                             pending
);

    localparam int SUM_BITS = PIXEL_BITS + 4;

    typedef struct packed {
        logic [ilbp_pkg::CODE_BITS-1:0] code;
        logic [ilbp_pkg::MEAN_BITS-1:0] mean;
        logic [COUNT_BITS-1:0]          count;
    } lbp_result_t;

    typedef logic [ilbp_pkg::WIN_SIZE-1:0][PIXEL_BITS-1:0] window_t;

    // model copy of the histogram and the results still owed by the block
    logic [COUNT_BITS-1:0] code_bins [ilbp_pkg::NUM_BINS];
    lbp_result_t           owed_results [$];

    // smallest of the nine left rotations
    function automatic logic [ilbp_pkg::CODE_BITS-1:0] min_rotation(
        input logic [ilbp_pkg::CODE_BITS-1:0] word
    );
        logic [ilbp_pkg::CODE_BITS-1:0] rot;
        logic [ilbp_pkg::CODE_BITS-1:0] best;
        rot  = word;
        best = word;
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
        begin
            if (rot < best)
                best = rot;
            rot = {rot[ilbp_pkg::CODE_BITS-2:0], rot[ilbp_pkg::CODE_BITS-1]};
        end
        return best;
    endfunction

    // mean, thresholded word, code and saturating bin update for one window
    function automatic lbp_result_t predict_window(input window_t win);
        lbp_result_t                    res;
        logic [SUM_BITS-1:0]            total;
        logic [SUM_BITS-1:0]            avg;
        logic [ilbp_pkg::CODE_BITS-1:0] word;
        total = '0;
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
            total = total + SUM_BITS'(win[k]);
        avg = total / SUM_BITS'(ilbp_pkg::WIN_SIZE);
        // pixel 0 lands in the top bit
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
            word[ilbp_pkg::CODE_BITS-1-k] = (SUM_BITS'(win[k]) >= avg);
        res.code = min_rotation(word);
        res.mean = avg[ilbp_pkg::MEAN_BITS-1:0];
        if (code_bins[res.code] != {COUNT_BITS{1'b1}})
            code_bins[res.code] = code_bins[res.code] + COUNT_BITS'(1);
        res.count = code_bins[res.code];
        return res;
    endfunction

    // results are checked before the same edge's item is predicted
    always @(posedge clk or negedge rst_n)
    begin
        lbp_result_t want;
        window_t     win;
        if (!rst_n)
        begin
            for (int b = 0; b < ilbp_pkg::NUM_BINS; b++)
                code_bins[b] = '0;
            owed_results.delete();
            pending = 0;
        end
        else
        begin
            // result side
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: code %0d mean %0d count %0d",
                             $time, pattern_code, window_mean, bin_count);
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (pattern_code !== want.code)
                    begin
                        $display("%0t: pattern_code expected %0d actual %0d",
                                 $time, want.code, pattern_code);
                        fail_count++;
                    end
                    if (window_mean !== want.mean)
                    begin
                        $display("%0t: window_mean expected %0d actual %0d",
                                 $time, want.mean, window_mean);
                        fail_count++;
                    end
                    if (bin_count !== want.count)
                    begin
                        $display("%0t: bin_count expected %0d actual %0d",
                                 $time, want.count, bin_count);
                        fail_count++;
                    end
                end
            end
            // item side
            if (in_valid && !in_stall)
            begin
                win = {pixel_8, pixel_7, pixel_6, pixel_5, pixel_4,
                       pixel_3, pixel_2, pixel_1, pixel_0};
                owed_results.push_back(predict_window(win));
            end
            pending = owed_results.size();
        end
    end

endmodule

FILE: bench/tb_ilbp_code_histogram_top.sv
`timescale 1ns / 1ps

module tb_ilbp_code_histogram_top;

    localparam int PIX_BITS   = 8;
    localparam int CNT_BITS   = 20;
    localparam int CLK_PERIOD = 12;
    localparam int RAND_ITEMS = 1030;

    typedef logic [ilbp_pkg::WIN_SIZE-1:0][PIX_BITS-1:0] window_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           out_stall = 1'b0;
    logic [PIX_BITS-1:0]            pixel_0   = '0;
    logic [PIX_BITS-1:0]            pixel_1   = '0;
    logic [PIX_BITS-1:0]            pixel_2   = '0;
    logic [PIX_BITS-1:0]            pixel_3   = '0;
    logic [PIX_BITS-1:0]            pixel_4   = '0;
    logic [PIX_BITS-1:0]            pixel_5   = '0;
    logic [PIX_BITS-1:0]            pixel_6   = '0;
    logic [PIX_BITS-1:0]            pixel_7   = '0;
    logic [PIX_BITS-1:0]            pixel_8   = '0;
    logic                           in_stall;
    logic                           out_valid;
    logic [ilbp_pkg::CODE_BITS-1:0] pattern_code;
    logic [ilbp_pkg::MEAN_BITS-1:0] window_mean;
    logic [CNT_BITS-1:0]            bin_count;
    int                             fail_count;
    int                             pending;
    bit                             quiet = 1'b0;

    // clock
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    ilbp_code_histogram_top #(
        .PIXEL_BITS (PIX_BITS),
        .COUNT_BITS (CNT_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_0      (pixel_0),
        .pixel_1      (pixel_1),
        .pixel_2      (pixel_2),
        .pixel_3      (pixel_3),
        .pixel_4      (pixel_4),
        .pixel_5      (pixel_5),
        .pixel_6      (pixel_6),
        .pixel_7      (pixel_7),
        .pixel_8      (pixel_8),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pattern_code (pattern_code),
        .window_mean  (window_mean),
        .bin_count    (bin_count)
    );

    ilbp_code_histogram_checker #(
        .PIXEL_BITS (PIX_BITS),
        .COUNT_BITS (CNT_BITS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_0      (pixel_0),
        .pixel_1      (pixel_1),
        .pixel_2      (pixel_2),
        .pixel_3      (pixel_3),
        .pixel_4      (pixel_4),
        .pixel_5      (pixel_5),
        .pixel_6      (pixel_6),
        .pixel_7      (pixel_7),
        .pixel_8      (pixel_8),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pattern_code (pattern_code),
        .window_mean  (window_mean),
        .bin_count    (bin_count),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // random backpressure on the result side
    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(99) < 33);

    // one level everywhere except one spot
    function automatic window_t spot(input int idx, input int hi, input int lo);
        window_t win;
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
            win[k] = (k == idx) ? hi[PIX_BITS-1:0] : lo[PIX_BITS-1:0];
        return win;
    endfunction

    // random window, mostly structured so that ties and uniform areas are common
    function automatic window_t random_window();
        window_t win;
        int      kind;
        int      base;
        int      lvl_a;
        int      lvl_b;
        int      val;
        kind  = $urandom_range(99);
        base  = $urandom_range(255);
        lvl_a = $urandom_range(255);
        lvl_b = $urandom_range(255);
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
        begin
            if (kind < 15)
                val = base;
            else if (kind < 40)
                val = $urandom_range(255);
            else if (kind < 65)
            begin
                val = base + $urandom_range(4) - 2;
                if (val < 0)
                    val = 0;
                if (val > 255)
                    val = 255;
            end
            else if (kind < 85)
                val = $urandom_range(1) ? lvl_a : lvl_b;
            else
                val = $urandom_range(1) ? 255 : 0;
            win[k] = val[PIX_BITS-1:0];
        end
        return win;
    endfunction

    // present one window and hold it until accepted
    task automatic send_window(input window_t win);
        bit taken;
        while (!quiet && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_0  <= win[0];
        pixel_1  <= win[1];
        pixel_2  <= win[2];
        pixel_3  <= win[3];
        pixel_4  <= win[4];
        pixel_5  <= win[5];
        pixel_6  <= win[6];
        pixel_7  <= win[7];
        pixel_8  <= win[8];
        forever
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
            if (taken)
                break;
        end
    endtask

    // stimulus and verdict
    initial
    begin
        window_t win;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: uniform windows, single bright and dark pixels, ramps, ties
        send_window(spot(0, 0, 0));
        send_window(spot(0, 255, 255));
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
            send_window(spot(k, 255, 0));
        send_window(spot(4, 0, 255));
        send_window(spot(0, 0, 255));
        send_window(spot(8, 1, 0));
        send_window(spot(4, 254, 255));
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
            win[k] = PIX_BITS'(k * 31);
        send_window(win);
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
            win[k] = PIX_BITS'(255 - k * 31);
        send_window(win);
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
            win[k] = (k % 2 != 0) ? PIX_BITS'(255) : PIX_BITS'(0);
        send_window(win);
        // pixel 4 equals the mean
        for (int k = 0; k < ilbp_pkg::WIN_SIZE; k++)
            win[k] = PIX_BITS'(k);
        send_window(win);

        // random part with a stretch free of idling and one full drain
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            quiet = (n >= 300 && n < 500);
            if (n == 600)
            begin
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending != 0);
                @(posedge clk);
            end
            send_window(random_window());
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        // drain, then allow for the pipeline
        do
            @(negedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_ilbp_code_histogram_top: PASS");
        else
            $display("tb_ilbp_code_histogram_top: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #(CLK_PERIOD * 200000);
        $display("tb_ilbp_code_histogram_top: FAIL");
        $finish;
    end

endmodule
